// File: rtl/amdc_pkg.sv
`timescale 1ns / 1ps

package amdc_pkg;

  // Fixed field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned EnvW    = 16;
  localparam int unsigned AudioW  = 18;
  localparam int unsigned CountW  = 32;
  localparam int unsigned PoleW   = 16;
  localparam int unsigned SqW     = 32;

  // Reset values
  localparam logic [PoleW-1:0] PoleReset  = 16'd64689;
  localparam logic [EnvW-1:0]  FloorReset = 16'd32768;

  // Saturation limits of the audio output
  localparam logic signed [AudioW-1:0] AudioMax = 18'sh1FFFF;
  localparam logic signed [AudioW-1:0] AudioMin = 18'sh20000;

  typedef struct packed {
    logic signed [SampleW-1:0] i_in;
    logic signed [SampleW-1:0] q_in;
  } in_item_t;

  typedef struct packed {
    logic signed [AudioW-1:0] audio_out;
    logic [EnvW-1:0]          envelope;
    logic [EnvW-1:0]          envelope_peak;
    logic [EnvW-1:0]          envelope_floor;
    logic [CountW-1:0]        sample_count;
  } out_item_t;

endpackage

// File: rtl/am_envelope_demod_dc_block.sv
`timescale 1ns / 1ps
// Path from input transfer to result: 1 squaring stage, queue,
// 16 square-root steps, 1 feedback multiply, 1 sum/saturate into the output register.
// The back end takes a new item only when idle; its iterative square root limits throughput.
// The front end and queue take up to three items ahead while the back end works.
// Reset (rst_ni, async, active low) clears all but datapath; pole to 64689, floor to 32768.
module am_envelope_demod_dc_block import amdc_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [PoleW-1:0] cfg_wdata_i
);

  logic [PoleW-1:0] pole_q;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [SqW-1:0]   f_sq, b_sq;

  // Pole coefficient register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q <= PoleReset;
    end else if (cfg_we_i) begin
      pole_q <= cfg_wdata_i;
    end
  end

  amdc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .sq_valid_o (f_valid),
    .sq_ready_i (f_ready),
    .sq_o       (f_sq)
  );

  amdc_fifo #(
    .Width (SqW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_sq),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_sq)
  );

  amdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pole_i      (pole_q),
    .sq_valid_i  (b_valid),
    .sq_ready_o  (b_ready),
    .sq_i        (b_sq),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/amdc_front.sv
`timescale 1ns / 1ps

module amdc_front import amdc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            sq_valid_o,
  input  logic            sq_ready_i,
  output logic [SqW-1:0]  sq_o
);

  logic           valid_q, valid_d;
  logic [SqW-1:0] sq_q, sq_d;
  logic signed [2*SampleW-1:0] ii, qq;

  // Power of the sample: I*I + Q*Q, at most 2^31
  assign ii   = in_data_i.i_in * in_data_i.i_in;
  assign qq   = in_data_i.q_in * in_data_i.q_in;
  assign sq_d = SqW'(unsigned'(ii)) + SqW'(unsigned'(qq));

  // Stage register toward the queue
  assign in_ready_o = !valid_q || sq_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_valid_o = valid_q;
  assign sq_o       = sq_q;

endmodule

// File: rtl/amdc_fifo.sv
`timescale 1ns / 1ps

module amdc_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/amdc_back.sv
`timescale 1ns / 1ps

module amdc_back import amdc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PoleW-1:0] pole_i,
  input  logic             sq_valid_i,
  output logic             sq_ready_o,
  input  logic [SqW-1:0]   sq_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StSum  = 2'd3;
  localparam int unsigned RootSteps = SqW / 2;
  localparam int unsigned StepW = $clog2(RootSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(RootSteps - 1);
  localparam int unsigned RemW = EnvW + 2;
  localparam int unsigned ProdW = PoleW + 1 + AudioW;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [SqW-1:0]   rad_q;
  logic [RemW-1:0]  rem_q;
  logic [EnvW-1:0]  root_q;
  logic signed [ProdW-1:0] prod_q;

  logic signed [AudioW-1:0] last_audio_q;
  logic [EnvW-1:0]          last_env_q, peak_q, floor_q;
  logic [CountW-1:0]        count_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic [RemW:0]   rem_sh, trial;
  logic            fits;
  logic            retire;
  logic signed [AudioW-1:0]  diff;
  logic signed [AudioW+1:0]  y_full;
  logic signed [AudioW-1:0]  y_sat;
  logic signed [ProdW-17:0]  fb;
  logic [EnvW-1:0] peak_d, floor_d;

  // Digit-by-digit square root, one result bit per cycle
  assign rem_sh = {rem_q[RemW-2:0], rad_q[SqW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // High-pass: y = x - x_prev + floor(pole * y_prev / 2^16), saturated
  assign diff   = $signed({2'b00, root_q}) - $signed({2'b00, last_env_q});
  assign fb     = prod_q[ProdW-1:16];
  assign y_full = {{2{diff[AudioW-1]}}, diff} + {fb[ProdW-17], fb};
  always_comb begin
    if (y_full[AudioW+1:AudioW-1] == 3'b000 || y_full[AudioW+1:AudioW-1] == 3'b111) begin
      y_sat = y_full[AudioW-1:0];
    end else if (y_full[AudioW+1]) begin
      y_sat = AudioMin;
    end else begin
      y_sat = AudioMax;
    end
  end

  assign peak_d  = (root_q > peak_q) ? root_q : peak_q;
  assign floor_d = (root_q < floor_q) ? root_q : floor_q;

  // A result retires once the output register is free
  assign retire     = (state_q == StSum) && (!out_valid_q || out_ready_i);
  assign sq_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (sq_valid_i) state_d = StRoot;
      end
      StRoot: begin
        if (step_q == LastStep) state_d = StMul;
      end
      StMul: begin
        state_d = StSum;
      end
      StSum: begin
        if (retire) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      step_q       <= '0;
      last_audio_q <= '0;
      last_env_q   <= '0;
      peak_q       <= '0;
      floor_q      <= FloorReset;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        step_q <= '0;
      end else if (state_q == StRoot) begin
        step_q <= step_q + 1'b1;
      end
      if (retire) begin
        out_valid_q  <= 1'b1;
        last_audio_q <= y_sat;
        last_env_q   <= root_q;
        peak_q       <= peak_d;
        floor_q      <= floor_d;
        count_q      <= count_q + 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && sq_valid_i) begin
      rad_q  <= sq_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == StRoot) begin
      rad_q <= {rad_q[SqW-3:0], 2'b00};
      if (fits) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[EnvW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem_sh);
        root_q <= {root_q[EnvW-2:0], 1'b0};
      end
    end
    if (state_q == StMul) begin
      prod_q <= $signed({1'b0, pole_i}) * last_audio_q;
    end
    if (retire) begin
      out_q.audio_out      <= y_sat;
      out_q.envelope       <= root_q;
      out_q.envelope_peak  <= peak_d;
      out_q.envelope_floor <= floor_d;
      out_q.sample_count   <= count_q + 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
